// ----- src/hssmc_pkg.sv -----
package hssmc_pkg;

  // default sizes of the position and tick counters
  localparam int unsigned POSITION_WIDTH_DEF = 32;
  localparam int unsigned INTERVAL_WIDTH_DEF = 16;

  // configuration register map
  localparam int unsigned     ADDR_WIDTH         = 3;
  localparam logic            REG_STEP_INTERVAL  = 1'b0;
  localparam logic [15:0]     STEP_INTERVAL_RST  = 16'd1000;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_MOVE_REL = 2'd1;
  localparam logic [1:0] OP_MOVE_ABS = 2'd2;
  localparam logic [1:0] OP_RELEASE  = 2'd3;

  // last entry of the half-step table
  localparam logic [2:0] PHASE_LAST = 3'd7;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] amount;
    logic               release_after;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         coils;
    logic signed [31:0] position;
    logic               busy_res;
    logic               accepted;
    logic               move_done;
  } out_item_t;

  // half-step coil pattern for each phase
  function automatic logic [3:0] coil_pattern(logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0: pat = 4'b0001;
      3'd1: pat = 4'b0011;
      3'd2: pat = 4'b0010;
      3'd3: pat = 4'b0110;
      3'd4: pat = 4'b0100;
      3'd5: pat = 4'b1100;
      3'd6: pat = 4'b1000;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

// ----- src/hssmc_core.sv -----
module hssmc_core #(
  parameter int unsigned POSITION_WIDTH = hssmc_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned INTERVAL_WIDTH = hssmc_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  hssmc_pkg::in_item_t  item_i,
  input  logic [15:0]          step_interval_i,
  output hssmc_pkg::out_item_t result_o
);

  // compare width for tick count against the interval register
  localparam int unsigned CmpW = (INTERVAL_WIDTH > 16) ? INTERVAL_WIDTH : 16;

  logic [2:0]                phase_q, phase_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [POSITION_WIDTH-1:0] steps_q, steps_d;
  logic                      backward_q, backward_d;
  logic                      moving_q, moving_d;
  logic                      release_q, release_d;
  logic [INTERVAL_WIDTH-1:0] cnt_q, cnt_d;
  logic [3:0]                coil_q, coil_d;

  logic signed [POSITION_WIDTH-1:0] amt_pw;
  logic [POSITION_WIDTH-1:0]        delta;
  logic [INTERVAL_WIDTH-1:0]        cnt_inc;
  logic [15:0]                      ivl;
  logic                             step_now;
  logic                             acc;
  logic                             done;

  // amount brought to position width, sign kept
  assign amt_pw  = POSITION_WIDTH'(item_i.amount);
  assign delta   = (item_i.operation == hssmc_pkg::OP_MOVE_REL) ? $unsigned(amt_pw)
                                                                : $unsigned(amt_pw) - pos_q;
  assign cnt_inc = cnt_q + INTERVAL_WIDTH'(1);
  assign ivl     = (step_interval_i == 16'd0) ? 16'd1 : step_interval_i;
  assign step_now = (CmpW'(cnt_inc) >= CmpW'(ivl)) || (cnt_inc == '0);

  // next state for the item at the input
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    steps_d    = steps_q;
    backward_d = backward_q;
    moving_d   = moving_q;
    release_d  = release_q;
    cnt_d      = cnt_q;
    coil_d     = coil_q;
    acc        = 1'b0;
    done       = 1'b0;
    unique case (item_i.operation) inside
      hssmc_pkg::OP_TICK: begin
        if (moving_q) begin
          if (step_now) begin
            cnt_d = '0;
            if (backward_q) begin
              phase_d = (phase_q == 3'd0) ? hssmc_pkg::PHASE_LAST : phase_q - 3'd1;
              pos_d   = pos_q - POSITION_WIDTH'(1);
            end else begin
              phase_d = (phase_q == hssmc_pkg::PHASE_LAST) ? 3'd0 : phase_q + 3'd1;
              pos_d   = pos_q + POSITION_WIDTH'(1);
            end
            coil_d  = hssmc_pkg::coil_pattern(phase_d);
            steps_d = steps_q - POSITION_WIDTH'(1);
            if (steps_d == '0) begin
              moving_d = 1'b0;
              done     = 1'b1;
              if (release_q) begin
                coil_d = 4'd0;
              end
            end
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      hssmc_pkg::OP_MOVE_REL, hssmc_pkg::OP_MOVE_ABS: begin
        if (delta == '0) begin
          acc = 1'b1;
        end else if (!moving_q) begin
          acc        = 1'b1;
          backward_d = delta[POSITION_WIDTH-1];
          steps_d    = delta[POSITION_WIDTH-1] ? (~delta + POSITION_WIDTH'(1)) : delta;
          release_d  = item_i.release_after;
          cnt_d      = '0;
          moving_d   = 1'b1;
        end
      end
      default: begin
        coil_d = 4'd0;
      end
    endcase
  end

  // result seen after the item is applied
  always_comb begin
    result_o.coils     = coil_d;
    result_o.position  = 32'($signed(pos_d));
    result_o.busy_res  = moving_d;
    result_o.accepted  = acc;
    result_o.move_done = done;
  end

  // motor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      pos_q      <= '0;
      steps_q    <= '0;
      backward_q <= 1'b0;
      moving_q   <= 1'b0;
      release_q  <= 1'b0;
      cnt_q      <= '0;
      coil_q     <= '0;
    end else if (item_valid_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      steps_q    <= steps_d;
      backward_q <= backward_d;
      moving_q   <= moving_d;
      release_q  <= release_d;
      cnt_q      <= cnt_d;
      coil_q     <= coil_d;
    end
  end

endmodule

// ----- src/half_step_stepper_move_controller.sv -----
// each result is registered in the output register, or in the skid entry while the output stalls
// throughput: one item per cycle while the skid entry is empty; the motor state updates in a single pass
// a two-entry output buffer keeps input taking items while one result waits
// reset: coils off, position and phase zero, idle, step interval 1000 ticks
module half_step_stepper_move_controller #(
  parameter int unsigned POSITION_WIDTH = hssmc_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned INTERVAL_WIDTH = hssmc_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  hssmc_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hssmc_pkg::out_item_t                out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hssmc_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [15:0]          step_interval_q;
  logic                 in_accept;
  logic                 out_ready;
  hssmc_pkg::out_item_t result;
  hssmc_pkg::out_item_t out_q;
  hssmc_pkg::out_item_t skid_q;
  logic                 out_valid_q;
  logic                 skid_valid_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hssmc_pkg::REG_STEP_INTERVAL) ? {16'd0, step_interval_q}
                                                             : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_interval_q <= hssmc_pkg::STEP_INTERVAL_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == hssmc_pkg::REG_STEP_INTERVAL) begin
      step_interval_q <= pwdata[15:0];
    end
  end

  // input handshake
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  hssmc_core #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .INTERVAL_WIDTH(INTERVAL_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_accept),
    .item_i         (in_item_i),
    .step_interval_i(step_interval_q),
    .result_o       (result)
  );

  // output register with skid entry
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q || in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- test/tb_top.sv -----
module tb_top;

  localparam int unsigned AW = hssmc_pkg::ADDR_WIDTH;

  // half-step coil patterns, phase 0 first
  localparam logic [3:0] HALF_STEP [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [AW-1:0] STEP_IVL_ADDR = AW'({hssmc_pkg::REG_STEP_INTERVAL, 2'b00});

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  hssmc_pkg::in_item_t  in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  hssmc_pkg::out_item_t out_item;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [AW-1:0]        paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // pending input items and expected status items
  hssmc_pkg::in_item_t  cmd_q [$];
  hssmc_pkg::out_item_t expected_status_q [$];
  hssmc_pkg::out_item_t want_item;

  int          err_cnt  = 0;
  int          gen_cnt  = 0;
  int          plan_pos = 0;
  int unsigned drv_cyc  = 0;
  int unsigned mon_cyc  = 0;

  // motor state as the predictor sees it
  logic [15:0] step_ivl_cfg = hssmc_pkg::STEP_INTERVAL_RST;
  logic [2:0]  ph_idx       = '0;
  logic [31:0] cur_pos      = '0;
  logic [31:0] steps_left   = '0;
  logic        dir_back     = 1'b0;
  logic        moving       = 1'b0;
  logic        rel_end      = 1'b0;
  logic [15:0] tick_cnt     = '0;
  logic [3:0]  coil_lv      = '0;

  half_step_stepper_move_controller uut (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // start a move of the given signed distance unless one is running
  function automatic logic try_start(logic [31:0] span, logic rel);
    if (span == '0) return 1'b1;
    if (moving) return 1'b0;
    dir_back   = span[31];
    steps_left = span[31] ? -span : span;
    rel_end    = rel;
    tick_cnt   = '0;
    moving     = 1'b1;
    return 1'b1;
  endfunction

  // apply one command item and return the status item it produces
  function automatic hssmc_pkg::out_item_t motor_step(hssmc_pkg::in_item_t it);
    hssmc_pkg::out_item_t r;
    logic [16:0]          ivl_eff;
    r = '0;
    case (it.operation)
      hssmc_pkg::OP_TICK: begin
        if (moving) begin
          ivl_eff  = (step_ivl_cfg == '0) ? 17'd1 : {1'b0, step_ivl_cfg};
          tick_cnt = tick_cnt + 16'd1;
          if ({1'b0, tick_cnt} >= ivl_eff || tick_cnt == '0) begin
            tick_cnt = '0;
            if (dir_back) begin
              ph_idx  = ph_idx - 3'd1;
              cur_pos = cur_pos - 32'd1;
            end else begin
              ph_idx  = ph_idx + 3'd1;
              cur_pos = cur_pos + 32'd1;
            end
            coil_lv    = HALF_STEP[ph_idx];
            steps_left = steps_left - 32'd1;
            if (steps_left == '0) begin
              moving      = 1'b0;
              r.move_done = 1'b1;
              if (rel_end) coil_lv = '0;
            end
          end
        end
      end
      hssmc_pkg::OP_MOVE_REL: r.accepted = try_start(it.amount, it.release_after);
      hssmc_pkg::OP_MOVE_ABS: r.accepted = try_start(it.amount - cur_pos, it.release_after);
      default: coil_lv = '0;
    endcase
    r.coils    = coil_lv;
    r.position = cur_pos;
    r.busy_res = moving;
    return r;
  endfunction

  // sender: predict on acceptance, then offer the next item or idle
  always @(posedge clk_i) begin
    drv_cyc <= drv_cyc + 1;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_status_q.push_back(motor_step(in_item));
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() != 0 &&
            ((drv_cyc >= 600 && drv_cyc < 800) || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          in_item  <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // receiver: compare each status item, stall at random and once for long
  always @(posedge clk_i) begin
    mon_cyc <= mon_cyc + 1;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0h", $time, out_item);
          err_cnt++;
        end else begin
          want_item = expected_status_q.pop_front();
          check_field("coils", 32'(want_item.coils), 32'(out_item.coils));
          check_field("position", want_item.position, out_item.position);
          check_field("busy_res", 32'(want_item.busy_res), 32'(out_item.busy_res));
          check_field("accepted", 32'(want_item.accepted), 32'(out_item.accepted));
          check_field("move_done", 32'(want_item.move_done), 32'(out_item.move_done));
        end
      end
      if (mon_cyc >= 300 && mon_cyc < 500)
        out_stall <= 1'b1;
      else if (mon_cyc >= 600 && mon_cyc < 800)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  task automatic push_cmd(logic [1:0] op, logic [31:0] amt, logic rel);
    hssmc_pkg::in_item_t it;
    it.operation     = op;
    it.amount        = amt;
    it.release_after = rel;
    cmd_q.push_back(it);
    gen_cnt++;
  endtask

  task automatic push_ticks(int n);
    for (int k = 0; k < n; k++)
      push_cmd(hssmc_pkg::OP_TICK, $urandom(), 1'($urandom_range(0, 1)));
  endtask

  // items that leave an idle motor where it is
  task automatic push_idle_noise();
    case ($urandom_range(0, 3))
      0: push_cmd(hssmc_pkg::OP_RELEASE, $urandom(), 1'($urandom_range(0, 1)));
      1: push_ticks(1);
      2: push_cmd(hssmc_pkg::OP_MOVE_REL, '0, 1'($urandom_range(0, 1)));
      default: push_cmd(hssmc_pkg::OP_MOVE_ABS, plan_pos, 1'($urandom_range(0, 1)));
    endcase
  endtask

  // items sent while a move runs: rejected moves, zero moves, releases
  task automatic push_busy_noise();
    case ($urandom_range(0, 3))
      0: push_cmd(hssmc_pkg::OP_RELEASE, $urandom(), 1'($urandom_range(0, 1)));
      1: push_cmd(hssmc_pkg::OP_MOVE_REL, $urandom(), 1'($urandom_range(0, 1)));
      2: push_cmd(hssmc_pkg::OP_MOVE_ABS, $urandom(), 1'($urandom_range(0, 1)));
      default: push_cmd(hssmc_pkg::OP_MOVE_REL, '0, 1'($urandom_range(0, 1)));
    endcase
  endtask

  // short move with just enough ticks to finish it, noise mixed in
  task automatic push_move_seq(int ivl_eff);
    int d;
    int needed;
    logic rel;
    d   = $urandom_range(1, 8);
    rel = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1)) d = -d;
    if ($urandom_range(0, 1)) push_cmd(hssmc_pkg::OP_MOVE_REL, d, rel);
    else push_cmd(hssmc_pkg::OP_MOVE_ABS, plan_pos + d, rel);
    plan_pos += d;
    needed = (d < 0 ? -d : d) * ivl_eff;
    for (int k = 0; k < needed; k++) begin
      if ($urandom_range(0, 99) < 12) push_busy_noise();
      push_ticks(1);
    end
    push_ticks($urandom_range(0, 2));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid || expected_status_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // write the step interval, then read it back
  task automatic set_step_interval(logic [15:0] val, logic [15:0] hi);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STEP_IVL_ADDR;
    pwdata  <= {hi, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    step_ivl_cfg = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    if (prdata[15:0] !== val) begin
      $display("%0t: step_interval readback mismatch, expected %0h, actual %0h",
               $time, val, prdata[15:0]);
      err_cnt++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // main sequence of phases
  initial begin
    int ivl_list [4];
    int eff;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset interval: idle items, zero moves, busy rejects, no step yet
    push_cmd(hssmc_pkg::OP_TICK, 32'h0000_0000, 1'b0);
    push_cmd(hssmc_pkg::OP_RELEASE, 32'hFFFF_FFFF, 1'b1);
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'h0000_0000, 1'b1);
    push_cmd(hssmc_pkg::OP_MOVE_ABS, 32'h0000_0000, 1'b0);
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'h0000_0001, 1'b0);
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'h7FFF_FFFF, 1'b1);
    push_cmd(hssmc_pkg::OP_MOVE_ABS, 32'h8000_0000, 1'b0);
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'h0000_0000, 1'b1);
    push_cmd(hssmc_pkg::OP_RELEASE, 32'h0000_0000, 1'b0);
    push_ticks(50);
    wait_idle();

    // shorter interval finishes the pending step at once
    set_step_interval(16'd2, 16'h0000);
    push_ticks(1);
    plan_pos = 1;

    // release mid move, backward move past phase zero
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'd3, 1'b1);
    push_ticks(2);
    push_cmd(hssmc_pkg::OP_RELEASE, $urandom(), 1'b0);
    push_ticks(4);
    push_cmd(hssmc_pkg::OP_MOVE_ABS, 32'd2, 1'b0);
    push_ticks(4);
    push_cmd(hssmc_pkg::OP_MOVE_REL, -32'sd3, 1'b0);
    push_ticks(6);
    plan_pos = -1;
    wait_idle();

    // random phases over several intervals, zero among them
    ivl_list = '{1, 0, 3, $urandom_range(2, 6)};
    foreach (ivl_list[i]) begin
      set_step_interval(16'(ivl_list[i]), 16'($urandom()));
      eff = (ivl_list[i] == 0) ? 1 : ivl_list[i];
      gen_cnt = 0;
      while (gen_cnt < 90) begin
        if ($urandom_range(0, 99) < 20) push_idle_noise();
        else push_move_seq(eff);
      end
      wait_idle();
    end

    // longest interval, then a shorter one below the running count
    set_step_interval(16'hFFFF, 16'h0000);
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'd1, 1'b1);
    push_ticks(20);
    wait_idle();
    set_step_interval(16'd3, 16'h0000);
    push_ticks(2);
    plan_pos += 1;
    wait_idle();

    // longest backward move never ends; extreme moves are rejected
    set_step_interval(16'd1, 16'h0000);
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'h8000_0000, 1'b0);
    push_ticks(10);
    push_cmd(hssmc_pkg::OP_MOVE_REL, 32'h7FFF_FFFF, 1'b1);
    push_cmd(hssmc_pkg::OP_MOVE_ABS, 32'h7FFF_FFFF, 1'b0);
    push_cmd(hssmc_pkg::OP_MOVE_ABS, 32'h8000_0000, 1'b1);
    push_cmd(hssmc_pkg::OP_RELEASE, 32'h0000_0000, 1'b0);
    push_ticks(5);
    wait_idle();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
